/* sv/prw_pkg.sv */
`timescale 1ns / 1ps
// prw_pkg: shared types and codes for the pretrigger window readout
// used by prw_csr, prw_core, prw_window and pretrigger_window_readout
package prw_pkg;

   // request selector carried on req_tuser
   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_EVENT = 2'd1,
      REQ_WORD  = 2'd2
   } req_type;

   // result kind carried on rsp_tuser
   typedef enum logic [2:0] {
      KIND_STARTED = 3'd0,
      KIND_WINDOW  = 3'd1,
      KIND_SKIPPED = 3'd2,
      KIND_NOTHING = 3'd3,
      KIND_SAMPLES = 3'd4
   } kind_type;

   // register index, byte address is 4 * index
   typedef enum logic [2:0] {
      REG_ARRAY_SIZE     = 3'd0,
      REG_EVENTS_LOG2    = 3'd1,
      REG_SAMPLES_WANTED = 3'd2,
      REG_HIGH_LEN       = 3'd3,
      REG_LOW_LEN        = 3'd4,
      REG_WIDE_SAMPLES   = 3'd5
   } reg_index_type;

   localparam int unsigned LenW    = 21;
   localparam int unsigned SampleW = 14;
   localparam int unsigned MaxLog2 = 4;

   localparam logic [SampleW-1:0] NarrowMask = 14'h0fff;
   localparam logic [SampleW-1:0] WideMask   = 14'h3fff;

   // settings derived from the registers, as the datapath uses them
   typedef struct packed {
      logic [LenW-1:0]    eventsize;
      logic [LenW-1:0]    wanted;
      logic [2:0]         seg_log2;
      logic [LenW-1:0]    high_len;
      logic [LenW-1:0]    low_len;
      logic               wide;
   } cfg_type;

   // item between the state stage and the window stage
   typedef struct packed {
      kind_type            kind;
      logic [LenW-1:0]     loc;
      logic signed [LenW:0] nmax;
      logic [LenW-1:0]     base;
      logic [LenW-1:0]     seg_end;
      logic [SampleW-1:0]  high_sample;
      logic                high_valid;
      logic [SampleW-1:0]  low_sample;
      logic                low_valid;
   } stage_type;

endpackage

/* sv/prw_csr.sv */
`timescale 1ns / 1ps
// prw_csr: configuration registers with APB-style access and derived settings
// depends on prw_pkg
module prw_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output prw_pkg::cfg_type      cfg,
   output logic                  geom_upd,
   output logic [prw_pkg::LenW-1:0] eventsize_next
);

   logic [prw_pkg::LenW-1:0] array_size_ff, array_size_in;
   logic [2:0]               events_log2_ff, events_log2_in;
   logic [prw_pkg::LenW-1:0] samples_wanted_ff, samples_wanted_in;
   logic [prw_pkg::LenW-1:0] high_len_ff, high_len_in;
   logic [prw_pkg::LenW-1:0] low_len_ff, low_len_in;
   logic                     wide_ff, wide_in;
   prw_pkg::cfg_type         cfg_ff, cfg_in;
   logic                     wr;
   logic [2:0]               seg_log2;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;

   // register writes
   always_comb begin
      array_size_in     = array_size_ff;
      events_log2_in    = events_log2_ff;
      samples_wanted_in = samples_wanted_ff;
      high_len_in       = high_len_ff;
      low_len_in        = low_len_ff;
      wide_in           = wide_ff;
      geom_upd          = 1'b0;
      if (wr) begin
         case (csr_paddr[4:2])
            prw_pkg::REG_ARRAY_SIZE: begin
               array_size_in = csr_pwdata[prw_pkg::LenW-1:0];
               geom_upd      = 1'b1;
            end
            prw_pkg::REG_EVENTS_LOG2: begin
               events_log2_in = csr_pwdata[2:0];
               geom_upd       = 1'b1;
            end
            prw_pkg::REG_SAMPLES_WANTED: samples_wanted_in = csr_pwdata[prw_pkg::LenW-1:0];
            prw_pkg::REG_HIGH_LEN:       high_len_in = csr_pwdata[prw_pkg::LenW-1:0];
            prw_pkg::REG_LOW_LEN:        low_len_in = csr_pwdata[prw_pkg::LenW-1:0];
            prw_pkg::REG_WIDE_SAMPLES:   wide_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // derived settings follow the next register values so they are ready at once
   always_comb begin
      seg_log2 = (events_log2_in > 3'(prw_pkg::MaxLog2)) ? 3'(prw_pkg::MaxLog2)
                                                        : events_log2_in;
      eventsize_next   = array_size_in >> seg_log2;
      cfg_in.eventsize = eventsize_next;
      cfg_in.seg_log2  = seg_log2;
      if ((samples_wanted_in == '0) || (samples_wanted_in > eventsize_next)) begin
         cfg_in.wanted = eventsize_next;
      end else begin
         cfg_in.wanted = samples_wanted_in;
      end
      cfg_in.high_len = high_len_in;
      cfg_in.low_len  = low_len_in;
      cfg_in.wide     = wide_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         array_size_ff     <= 21'd262144;
         events_log2_ff    <= 3'd0;
         samples_wanted_ff <= '0;
         high_len_ff       <= 21'd1024;
         low_len_ff        <= 21'd1024;
         wide_ff           <= 1'b0;
         cfg_ff.eventsize  <= 21'd262144;
         cfg_ff.wanted     <= 21'd262144;
         cfg_ff.seg_log2   <= 3'd0;
         cfg_ff.high_len   <= 21'd1024;
         cfg_ff.low_len    <= 21'd1024;
         cfg_ff.wide       <= 1'b0;
      end else begin
         array_size_ff     <= array_size_in;
         events_log2_ff    <= events_log2_in;
         samples_wanted_ff <= samples_wanted_in;
         high_len_ff       <= high_len_in;
         low_len_ff        <= low_len_in;
         wide_ff           <= wide_in;
         cfg_ff            <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // readback
   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[4:2])
         prw_pkg::REG_ARRAY_SIZE:     csr_prdata = 32'(array_size_ff);
         prw_pkg::REG_EVENTS_LOG2:    csr_prdata = 32'(events_log2_ff);
         prw_pkg::REG_SAMPLES_WANTED: csr_prdata = 32'(samples_wanted_ff);
         prw_pkg::REG_HIGH_LEN:       csr_prdata = 32'(high_len_ff);
         prw_pkg::REG_LOW_LEN:        csr_prdata = 32'(low_len_ff);
         prw_pkg::REG_WIDE_SAMPLES:   csr_prdata = 32'(wide_ff);
         default:                     csr_prdata = '0;
      endcase
   end

endmodule

/* sv/prw_core.sv */
`timescale 1ns / 1ps
// prw_core: readout state (event index, segment base, counts, skips) and the
// per-item decision stage; depends on prw_pkg
module prw_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [1:0]               req_type_in,
   input  logic [31:0]              trigger_count,
   input  logic [31:0]              memory_word,
   input  prw_pkg::cfg_type         cfg,
   input  logic                     geom_upd,
   input  logic [prw_pkg::LenW-1:0] eventsize_next,
   input  logic                     out_free,
   output logic                     stage_valid,
   output prw_pkg::stage_type       stage_item
);

   localparam int unsigned W = prw_pkg::LenW;

   logic [4:0]         event_index_ff, event_index_in;
   logic [W-1:0]       base_ff, base_in;
   logic [W-1:0]       high_count_ff, high_count_in;
   logic [W-1:0]       low_count_ff, low_count_in;
   logic [W-1:0]       skip_high_ff, skip_high_in;
   logic [W-1:0]       skip_low_ff, skip_low_in;
   logic               stage_valid_ff, stage_valid_in;
   prw_pkg::stage_type stage_ff, stage_in;

   logic               take;
   logic               idx_ok;
   logic [W-1:0]       seg_end;
   logic [32:0]        trig_diff;
   logic               in_range;
   logic [W-1:0]       loc_inc;
   logic [W-1:0]       loc;
   logic signed [W:0]  want_s, hd, ld, nh, nl, nmax;
   logic signed [W:0]  skip_h, skip_l;
   logic [prw_pkg::SampleW-1:0] mask;
   logic [25:0]        base_prod;

   assign req_tready = !stage_valid_ff || out_free;
   assign take       = req_tvalid && req_tready;

   // event window arithmetic
   always_comb begin
      idx_ok    = {1'b0, event_index_ff} < (6'd1 << cfg.seg_log2);
      seg_end   = base_ff + cfg.eventsize;
      trig_diff = {1'b0, trigger_count} - {12'd0, base_ff};
      in_range  = !trig_diff[32] && (trig_diff[31:0] < {11'd0, cfg.eventsize});
      loc_inc   = trig_diff[W-1:0] + W'(1);
      loc       = (loc_inc == cfg.eventsize) ? '0 : loc_inc;
      want_s    = $signed({1'b0, cfg.wanted});
      hd        = $signed({1'b0, cfg.high_len}) - $signed({1'b0, high_count_ff});
      ld        = $signed({1'b0, cfg.low_len}) - $signed({1'b0, low_count_ff});
      nh        = (hd > want_s) ? want_s : hd;
      nl        = (ld > want_s) ? want_s : ld;
      nmax      = (nh > nl) ? nh : nl;
      skip_h    = nmax - nh;
      skip_l    = nmax - nl;
      mask      = cfg.wide ? prw_pkg::WideMask : prw_pkg::NarrowMask;
      base_prod = event_index_ff * eventsize_next;
   end

   // state update and stage item for one accepted item
   always_comb begin
      event_index_in = event_index_ff;
      base_in        = base_ff;
      high_count_in  = high_count_ff;
      low_count_in   = low_count_ff;
      skip_high_in   = skip_high_ff;
      skip_low_in    = skip_low_ff;
      stage_valid_in = stage_valid_ff && !out_free;

      stage_in             = '0;
      stage_in.kind        = prw_pkg::KIND_SKIPPED;
      stage_in.loc         = loc;
      stage_in.nmax        = nmax;
      stage_in.base        = base_ff;
      stage_in.seg_end     = seg_end;
      stage_in.high_sample = memory_word[16 +: prw_pkg::SampleW] & mask;
      stage_in.low_sample  = memory_word[0 +: prw_pkg::SampleW] & mask;

      if (take) begin
         case (req_type_in)
            prw_pkg::REQ_START: begin
               stage_valid_in = 1'b1;
               stage_in.kind  = prw_pkg::KIND_STARTED;
               event_index_in = '0;
               base_in        = '0;
               high_count_in  = '0;
               low_count_in   = '0;
               skip_high_in   = '0;
               skip_low_in    = '0;
            end
            prw_pkg::REQ_EVENT: begin
               stage_valid_in = 1'b1;
               if (idx_ok) begin
                  event_index_in = event_index_ff + 5'd1;
                  base_in        = seg_end;
                  if (in_range) begin
                     if (nmax <= 0) begin
                        stage_in.kind = prw_pkg::KIND_NOTHING;
                     end else begin
                        stage_in.kind = prw_pkg::KIND_WINDOW;
                        skip_high_in  = skip_h[W-1:0];
                        skip_low_in   = skip_l[W-1:0];
                     end
                  end
               end
            end
            prw_pkg::REQ_WORD: begin
               stage_valid_in = 1'b1;
               stage_in.kind  = prw_pkg::KIND_SAMPLES;
               if (skip_high_ff != '0) begin
                  skip_high_in = skip_high_ff - W'(1);
               end else if (high_count_ff < cfg.high_len) begin
                  high_count_in       = high_count_ff + W'(1);
                  stage_in.high_valid = 1'b1;
               end
               if (skip_low_ff != '0) begin
                  skip_low_in = skip_low_ff - W'(1);
               end else if (low_count_ff < cfg.low_len) begin
                  low_count_in       = low_count_ff + W'(1);
                  stage_in.low_valid = 1'b1;
               end
            end
            default: ;
         endcase
      end else if (geom_upd) begin
         // segment size changed while idle: rebuild the base of the current event
         base_in = base_prod[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_index_ff <= '0;
         base_ff        <= '0;
         high_count_ff  <= '0;
         low_count_ff   <= '0;
         skip_high_ff   <= '0;
         skip_low_ff    <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         event_index_ff <= event_index_in;
         base_ff        <= base_in;
         high_count_ff  <= high_count_in;
         low_count_ff   <= low_count_in;
         skip_high_ff   <= skip_high_in;
         skip_low_ff    <= skip_low_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_item  = stage_ff;

endmodule

/* sv/prw_window.sv */
`timescale 1ns / 1ps
// prw_window: forms the one or two read runs and holds the result register
// depends on prw_pkg
module prw_window #(
   parameter int GROUP_ADDR_BITS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               stage_valid,
   input  prw_pkg::stage_type stage_item,
   output logic               out_free,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [2:0]         rsp_tuser,   // kind
   // first_address, first_length, second_address, second_length,
   // high_sample, high_valid, low_sample, low_valid
   output logic [111:0]       rsp_tdata
);

   localparam int unsigned W        = prw_pkg::LenW;
   localparam int          MaskBits = (GROUP_ADDR_BITS < 20) ? GROUP_ADDR_BITS : 20;
   localparam logic [19:0] AddrMask = 20'((64'd1 << MaskBits) - 64'd1);

   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        kind_ff, kind_in;
   logic [111:0]      data_ff, data_in;

   logic signed [W:0] diff;
   logic [W-1:0]      neg_diff;
   logic [W-1:0]      first_addr, first_len, second_len;
   logic [19:0]       first_out, second_out;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // run split: wrap when the window reaches back past the event base
   always_comb begin
      diff     = stage_item.nmax - $signed({1'b0, stage_item.loc});
      neg_diff = W'(-diff);
      if (diff > 0) begin
         first_addr = stage_item.seg_end - diff[W-1:0];
         first_len  = diff[W-1:0];
         second_len = stage_item.loc;
      end else begin
         first_addr = stage_item.base + neg_diff;
         first_len  = stage_item.nmax[W-1:0];
         second_len = '0;
      end
      first_out  = first_addr[19:0] & AddrMask;
      second_out = stage_item.base[19:0] & AddrMask;
   end

   // result packing
   always_comb begin
      kind_in = stage_item.kind;
      data_in = '0;
      case (stage_item.kind)
         prw_pkg::KIND_WINDOW: begin
            data_in[19:0]  = first_out;
            data_in[40:20] = first_len;
            data_in[60:41] = second_out;
            data_in[81:61] = second_len;
         end
         prw_pkg::KIND_SAMPLES: begin
            data_in[95:82]  = stage_item.high_sample;
            data_in[96]     = stage_item.high_valid;
            data_in[110:97] = stage_item.low_sample;
            data_in[111]    = stage_item.low_valid;
         end
         default: ;
      endcase
      rsp_valid_in = stage_valid || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid && out_free) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = data_ff;

endmodule

/* sv/pretrigger_window_readout.sv */
`timescale 1ns / 1ps
// Readout engine for one channel group of a multi-event pre/post-trigger
// digitizer. Requests enter on req_* (tuser selects start, event or memory
// word; tdata carries trigger count and memory word). Results leave on rsp_*
// with one result item per start, event or word request; a request with
// selector 3 is taken and dropped. Registers sit on the csr_* port at 4*index.
// Pipeline: two register stages; an accepted request loads the state stage,
// and the result register loads from it once free, which raises rsp_tvalid.
// Throughput: one item per cycle unless rsp_tready stalls the result register,
// since counts and skips update in the state stage and the next item sees them.
// Stall: when rsp_tready is low the result register holds, the state stage
// still takes one more item, and req_tready drops once both are full.
// Reset: synchronous; counts, skips, event index and segment base clear,
// registers return to their defaults and no result is pending.
// Register writes are expected only while no item is in flight.
// Depends on prw_pkg, prw_csr, prw_core and prw_window.
module pretrigger_window_readout #(
   parameter int GROUP_ADDR_BITS = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // req_type
   input  logic [63:0]  req_tdata,   // trigger_count, memory_word
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,   // kind
   // first_address, first_length, second_address, second_length,
   // high_sample, high_valid, low_sample, low_valid
   output logic [111:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   prw_pkg::cfg_type         cfg;
   logic                     geom_upd;
   logic [prw_pkg::LenW-1:0] eventsize_next;
   logic                     out_free;
   logic                     stage_valid;
   prw_pkg::stage_type       stage_item;

   // configuration registers
   prw_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .cfg            (cfg),
      .geom_upd       (geom_upd),
      .eventsize_next (eventsize_next)
   );

   // state stage
   prw_core u_core (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_type_in    (req_tuser),
      .trigger_count  (req_tdata[31:0]),
      .memory_word    (req_tdata[63:32]),
      .cfg            (cfg),
      .geom_upd       (geom_upd),
      .eventsize_next (eventsize_next),
      .out_free       (out_free),
      .stage_valid    (stage_valid),
      .stage_item     (stage_item)
   );

   // run split and result register
   prw_window #(
      .GROUP_ADDR_BITS (GROUP_ADDR_BITS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_item  (stage_item),
      .out_free    (out_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

`ifndef SYNTHESIS
   // a window result always has a nonempty first run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == prw_pkg::KIND_WINDOW) |-> (rsp_tdata[40:20] != '0))
      else $error("window item with empty first run");

   // runs are reported only on window items
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != prw_pkg::KIND_WINDOW) |-> (rsp_tdata[81:0] == '0))
      else $error("run fields set on a non-window item");

   // samples are reported only on sample items
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != prw_pkg::KIND_SAMPLES) |-> (rsp_tdata[111:82] == '0))
      else $error("sample fields set on a non-sample item");

   // nothing is pending right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// testbench for pretrigger_window_readout: start, event and memory word items
// are checked against a predictor of the readout under random stalls on both sides
// depends on prw_pkg and the pretrigger_window_readout rtl
module testbench;

   // selector value that the block takes and drops
   localparam logic [1:0] ReqUnused = 2'd3;
   localparam int HoldCycles = 300;
   // longest quiet stretch is the receiver hold, plus settle and register writes
   localparam int WatchdogLimit = 4000;
   localparam int RandomItems = 600;
   localparam int SettleCycles = 6;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic              low_valid;
      logic [13:0]       low_sample;
      logic              high_valid;
      logic [13:0]       high_sample;
      logic [20:0]       second_length;
      logic [19:0]       second_address;
      logic [20:0]       first_length;
      logic [19:0]       first_address;
   } readout_fields_type;

   typedef struct packed {
      prw_pkg::kind_type  kind;
      readout_fields_type fields;
   } readout_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [1:0]    req_tuser = prw_pkg::REQ_START;  // req_type
   logic [63:0]   req_tdata = '0;                  // trigger_count, memory_word
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [2:0]    rsp_tuser;              // kind
   // first_address, first_length, second_address, second_length,
   // high_sample, high_valid, low_sample, low_valid
   logic [111:0]  rsp_tdata;
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [4:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   // predictor copy of registers and readout state
   logic [20:0]   cfg_array_size = 21'd262144;
   logic [2:0]    cfg_events_log2 = '0;
   logic [20:0]   cfg_samples_wanted = '0;
   logic [20:0]   cfg_high_len = 21'd1024;
   logic [20:0]   cfg_low_len = 21'd1024;
   logic          cfg_wide = 1'b0;
   logic [4:0]    event_index = '0;
   logic [20:0]   high_count = '0;
   logic [20:0]   low_count = '0;
   logic [20:0]   skip_high = '0;
   logic [20:0]   skip_low = '0;

   readout_result_type expected_results[$];
   int            error_count = 0;
   int            sent_items = 0;
   int            req_idle_pct = 13;
   int            rsp_idle_pct = 13;
   int            holds_asked = 0;
   int            holds_taken = 0;
   int            hold_left = 0;
   int            quiet_cycles = 0;

   pretrigger_window_readout dut (.*);

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result receiver: random stalls, or a long hold when asked
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_taken != holds_asked) begin
         holds_taken <= holds_asked;
         hold_left <= HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchdogLimit) begin
         $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: mismatch %s expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // result checker, oldest expectation first
   always @(posedge clock) begin
      readout_result_type want;
      readout_fields_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_results.size() == 0) begin
            $display("%0t: result item of kind %0d with nothing pending", $time, rsp_tuser);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("kind", want.kind, rsp_tuser);
            check_field("first_address", want.fields.first_address, got.first_address);
            check_field("first_length", want.fields.first_length, got.first_length);
            check_field("second_address", want.fields.second_address, got.second_address);
            check_field("second_length", want.fields.second_length, got.second_length);
            check_field("high_sample", want.fields.high_sample, got.high_sample);
            check_field("high_valid", want.fields.high_valid, got.high_valid);
            check_field("low_sample", want.fields.low_sample, got.low_sample);
            check_field("low_valid", want.fields.low_valid, got.low_valid);
         end
      end
   end

   // expected result of one accepted item, updates the predictor state
   function automatic void predict_readout(input logic [1:0] sel, input logic [31:0] trigger,
                                           input logic [31:0] word);
      readout_result_type r;
      logic [13:0] mask;
      logic [2:0] seg_log2;
      longint segment, base, trig64, loc, wanted, high_room, low_room, nmax, tail, cap, cnt;
      r = '0;
      case (sel)
         prw_pkg::REQ_START: begin
            event_index = '0;
            high_count = '0;
            low_count = '0;
            skip_high = '0;
            skip_low = '0;
            r.kind = prw_pkg::KIND_STARTED;
         end
         prw_pkg::REQ_EVENT: begin
            seg_log2 = (cfg_events_log2 > prw_pkg::MaxLog2) ? 3'(prw_pkg::MaxLog2)
                                                             : cfg_events_log2;
            segment = cfg_array_size >> seg_log2;
            base = event_index * segment;
            trig64 = trigger;
            r.kind = prw_pkg::KIND_SKIPPED;
            // index holds once past the last event
            if (int'(event_index) < (1 << seg_log2)) begin
               event_index = event_index + 5'd1;
               if (trig64 >= base && trig64 - base < segment) begin
                  loc = trig64 - base + 1;
                  if (loc == segment) loc = 0;
                  wanted = cfg_samples_wanted;
                  if (wanted > segment || wanted == 0) wanted = segment;
                  cap = cfg_high_len;
                  cnt = high_count;
                  high_room = cap - cnt;
                  if (high_room > wanted) high_room = wanted;
                  cap = cfg_low_len;
                  cnt = low_count;
                  low_room = cap - cnt;
                  if (low_room > wanted) low_room = wanted;
                  nmax = (high_room > low_room) ? high_room : low_room;
                  if (nmax <= 0) begin
                     r.kind = prw_pkg::KIND_NOTHING;
                  end else begin
                     skip_high = 21'(nmax - high_room);
                     skip_low = 21'(nmax - low_room);
                     r.kind = prw_pkg::KIND_WINDOW;
                     // window wraps: tail of the segment, then from its base
                     if (loc < nmax) begin
                        tail = nmax - loc;
                        r.fields.first_address = 20'(base + segment - tail);
                        r.fields.first_length = 21'(tail);
                        r.fields.second_length = 21'(loc);
                     end else begin
                        r.fields.first_address = 20'(base + loc - nmax);
                        r.fields.first_length = 21'(nmax);
                     end
                     r.fields.second_address = 20'(base);
                  end
               end
            end
         end
         prw_pkg::REQ_WORD: begin
            mask = cfg_wide ? prw_pkg::WideMask : prw_pkg::NarrowMask;
            r.kind = prw_pkg::KIND_SAMPLES;
            r.fields.high_sample = word[29:16] & mask;
            r.fields.low_sample = word[13:0] & mask;
            if (skip_high != 0) begin
               skip_high = skip_high - 21'd1;
            end else if (high_count < cfg_high_len) begin
               high_count = high_count + 21'd1;
               r.fields.high_valid = 1'b1;
            end
            if (skip_low != 0) begin
               skip_low = skip_low - 21'd1;
            end else if (low_count < cfg_low_len) begin
               low_count = low_count + 21'd1;
               r.fields.low_valid = 1'b1;
            end
         end
         default: return;
      endcase
      expected_results.push_back(r);
   endfunction

   // register write: setup cycle, then access cycle
   task automatic write_register(input prw_pkg::reg_index_type reg_sel,
                                 input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (reg_sel)
         prw_pkg::REG_ARRAY_SIZE:     cfg_array_size = value[20:0];
         prw_pkg::REG_EVENTS_LOG2:    cfg_events_log2 = value[2:0];
         prw_pkg::REG_SAMPLES_WANTED: cfg_samples_wanted = value[20:0];
         prw_pkg::REG_HIGH_LEN:       cfg_high_len = value[20:0];
         prw_pkg::REG_LOW_LEN:        cfg_low_len = value[20:0];
         prw_pkg::REG_WIDE_SAMPLES:   cfg_wide = value[0];
         default: ;
      endcase
   endtask

   // offer one item, with random idle cycles ahead of it
   task automatic send_item(input logic [1:0] sel, input logic [31:0] trigger,
                            input logic [31:0] word);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= sel;
      req_tdata <= {word, trigger};
      do @(posedge clock); while (!req_tready);
      predict_readout(sel, trigger, word);
      if (sel != ReqUnused) sent_items++;
   endtask

   // all results in, then let any dropped item leave the pipeline
   task automatic wait_readout_idle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // reset settings: wrapped window, past the last event, out of segment, unknown selector
   task automatic test_default_window();
      send_item(prw_pkg::REQ_START, $urandom(), $urandom());
      send_item(prw_pkg::REQ_EVENT, 32'd262143, $urandom());
      send_item(prw_pkg::REQ_WORD, $urandom(), 32'hffff_ffff);
      send_item(prw_pkg::REQ_WORD, $urandom(), 32'h0000_0000);
      send_item(prw_pkg::REQ_WORD, $urandom(), 32'h5a5a_a5a5);
      send_item(ReqUnused, $urandom(), $urandom());
      send_item(prw_pkg::REQ_EVENT, 32'd262143, $urandom());
      send_item(prw_pkg::REQ_START, $urandom(), $urandom());
      send_item(prw_pkg::REQ_EVENT, 32'hffff_ffff, $urandom());
      send_item(prw_pkg::REQ_START, $urandom(), $urandom());
      send_item(prw_pkg::REQ_EVENT, 32'd5, $urandom());
      wait_readout_idle();
   endtask

   // zero-size segment, oversize events_log2, largest sizes and wide samples
   task automatic test_special_segments();
      write_register(prw_pkg::REG_ARRAY_SIZE, 32'd1);
      write_register(prw_pkg::REG_EVENTS_LOG2, 32'd1);
      send_item(prw_pkg::REQ_START, $urandom(), $urandom());
      send_item(prw_pkg::REQ_EVENT, 32'd0, $urandom());
      wait_readout_idle();
      write_register(prw_pkg::REG_ARRAY_SIZE, 32'd1048576);
      write_register(prw_pkg::REG_EVENTS_LOG2, 32'd7);
      write_register(prw_pkg::REG_SAMPLES_WANTED, 32'd1048576);
      write_register(prw_pkg::REG_HIGH_LEN, 32'd1048576);
      write_register(prw_pkg::REG_LOW_LEN, 32'd0);
      write_register(prw_pkg::REG_WIDE_SAMPLES, 32'd1);
      send_item(prw_pkg::REQ_START, $urandom(), $urandom());
      send_item(prw_pkg::REQ_EVENT, 32'd65535, $urandom());
      send_item(prw_pkg::REQ_WORD, $urandom(), 32'hffff_ffff);
      send_item(prw_pkg::REQ_WORD, $urandom(), 32'h8000_4001);
      send_item(prw_pkg::REQ_EVENT, 32'd65636, $urandom());
      wait_readout_idle();
   endtask

   // counts above a lowered capacity, then an event with unequal skips
   task automatic test_capacity_limits();
      write_register(prw_pkg::REG_ARRAY_SIZE, 32'd16);
      write_register(prw_pkg::REG_EVENTS_LOG2, 32'd1);
      write_register(prw_pkg::REG_SAMPLES_WANTED, 32'd4);
      write_register(prw_pkg::REG_HIGH_LEN, 32'd8);
      write_register(prw_pkg::REG_LOW_LEN, 32'd8);
      write_register(prw_pkg::REG_WIDE_SAMPLES, 32'd0);
      send_item(prw_pkg::REQ_START, $urandom(), $urandom());
      repeat (3) send_item(prw_pkg::REQ_WORD, $urandom(), $urandom());
      wait_readout_idle();
      write_register(prw_pkg::REG_HIGH_LEN, 32'd1);
      write_register(prw_pkg::REG_LOW_LEN, 32'd2);
      send_item(prw_pkg::REQ_EVENT, 32'd3, $urandom());
      send_item(prw_pkg::REQ_WORD, $urandom(), $urandom());
      wait_readout_idle();
      write_register(prw_pkg::REG_LOW_LEN, 32'd8);
      send_item(prw_pkg::REQ_EVENT, 32'd9, $urandom());
      repeat (2) send_item(prw_pkg::REQ_WORD, $urandom(), $urandom());
      wait_readout_idle();
   endtask

   // receiver holds off while words keep coming, then no idling at all
   task automatic test_output_stall();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_item(prw_pkg::REQ_START, $urandom(), $urandom());
      holds_asked <= holds_asked + 1;
      repeat (40) send_item(prw_pkg::REQ_WORD, $urandom(), $urandom());
      wait_readout_idle();
      req_idle_pct = 13;
      rsp_idle_pct = 13;
   endtask

   // random settings, mostly well-formed readouts with random content
   task automatic test_random_readouts();
      int goal;
      int phase_goal;
      int phase;
      longint segment;
      longint offset;
      logic [31:0] trigger;
      goal = sent_items + RandomItems;
      phase = 0;
      while (sent_items < goal) begin
         case ($urandom_range(9))
            0: write_register(prw_pkg::REG_ARRAY_SIZE, 32'd1);
            1: write_register(prw_pkg::REG_ARRAY_SIZE, 32'd1048576);
            2: write_register(prw_pkg::REG_ARRAY_SIZE, $urandom_range(1, 1048576));
            default: write_register(prw_pkg::REG_ARRAY_SIZE, $urandom_range(1, 256));
         endcase
         write_register(prw_pkg::REG_EVENTS_LOG2, $urandom_range(0, 7));
         write_register(prw_pkg::REG_SAMPLES_WANTED, ($urandom_range(4) == 0) ?
                        $urandom_range(0, 1048576) : $urandom_range(0, 40));
         write_register(prw_pkg::REG_HIGH_LEN, ($urandom_range(5) == 0) ?
                        ($urandom_range(1) ? 32'd1048576 : 32'd0) : $urandom_range(0, 48));
         write_register(prw_pkg::REG_LOW_LEN, ($urandom_range(5) == 0) ?
                        ($urandom_range(1) ? 32'd1048576 : 32'd0) : $urandom_range(0, 48));
         write_register(prw_pkg::REG_WIDE_SAMPLES, $urandom_range(1));
         // one phase runs with no idling on either side
         req_idle_pct = (phase == 3) ? 0 : 13;
         rsp_idle_pct = (phase == 3) ? 0 : 13;
         phase_goal = sent_items + $urandom_range(60, 120);
         while (sent_items < phase_goal) begin
            send_item(prw_pkg::REQ_START, $urandom(), $urandom());
            repeat ($urandom_range(1, 18)) begin
               segment = cfg_array_size >>
                         ((cfg_events_log2 > prw_pkg::MaxLog2) ? prw_pkg::MaxLog2
                                                               : cfg_events_log2);
               // trigger inside the current segment, ends favored; some noise
               if ($urandom_range(7) == 0 || segment == 0) begin
                  trigger = $urandom();
               end else begin
                  case ($urandom_range(3))
                     0: offset = 0;
                     1: offset = segment - 1;
                     default: offset = $urandom_range(0, 32'(segment - 1));
                  endcase
                  trigger = 32'(event_index * segment + offset);
               end
               send_item(prw_pkg::REQ_EVENT, trigger, $urandom());
               repeat ($urandom_range(0, 20)) begin
                  case ($urandom_range(29))
                     0: send_item(ReqUnused, $urandom(), $urandom());
                     1: send_item(prw_pkg::REQ_START, $urandom(), $urandom());
                     default: send_item(prw_pkg::REQ_WORD, $urandom(), $urandom());
                  endcase
               end
            end
         end
         wait_readout_idle();
         phase++;
      end
      req_idle_pct = 13;
      rsp_idle_pct = 13;
   endtask

   // test sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_default_window();
      test_special_segments();
      test_capacity_limits();
      test_output_stall();
      test_random_readouts();
      wait_readout_idle();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* files.f */
sv/prw_pkg.sv
sv/prw_csr.sv
sv/prw_core.sv
sv/prw_window.sv
sv/pretrigger_window_readout.sv
tb/sv/testbench.sv
